[rtl/core/assert_macros.svh]
// Assertion helpers shared by the checker files.
// Both take a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PRS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("prs_checker: same-cycle implication violated");

// Next-cycle implication.
`define PRS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("prs_checker: next-cycle implication violated");

`endif

[rtl/core/prs_pkg.sv]
`default_nettype none

package prs_pkg;

  // Input op codes.
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_LIST    = 3'd1;
  localparam logic [2:0] OP_GROUP   = 3'd2;
  localparam logic [2:0] OP_ALL_OFF = 3'd3;
  localparam logic [2:0] OP_INIT    = 3'd4;

  // Error codes.
  localparam logic [2:0] ERR_NONE           = 3'd0;
  localparam logic [2:0] ERR_BUSY           = 3'd1;
  localparam logic [2:0] ERR_TOO_MANY       = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN_DEVICE = 3'd3;
  localparam logic [2:0] ERR_CONFLICT       = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN_GROUP  = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DEVICE_COUNT     = 3'd0;
  localparam logic [2:0] CFG_ACTIVE_HIGH_MASK = 3'd1;
  localparam logic [2:0] CFG_DEFAULT_ON_MASK  = 3'd2;
  localparam logic [2:0] CFG_GROUP_MAP        = 3'd3;
  localparam logic [2:0] CFG_DELAY_LOW        = 3'd4;
  localparam logic [2:0] CFG_DELAY_HIGH       = 3'd5;

  typedef enum logic [2:0] {
    K_TICK,
    K_LIST,
    K_GROUP,
    K_ALL_OFF,
    K_INIT,
    K_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [2:0] device;
    logic       turn_on;
    logic [2:0] group_number;
    logic       last_item;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  device_count;
    logic [7:0]  active_high_mask;
    logic [7:0]  default_on_mask;
    logic [23:0] group_map;
    logic [63:0] delay_table_low;
    logic [63:0] delay_table_high;
  } cfg_regs_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] error_code;
    logic [2:0] error_device;
    logic       busy_res;
    logic [7:0] device_on;
    logic [7:0] pin_levels;
    logic       applied_valid;
    logic [2:0] applied_device;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_FINISH
  } back_state_t;

endpackage

`default_nettype wire

[rtl/core/prs_in_if.sv]
`default_nettype none

interface prs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [2:0] device;
  logic       turn_on;
  logic [2:0] group_number;
  logic       last_item;

  modport source (output valid, output op, output device, output turn_on,
                  output group_number, output last_item, input ready);
  modport sink   (input valid, input op, input device, input turn_on,
                  input group_number, input last_item, output ready);
endinterface

`default_nettype wire

[rtl/core/prs_out_if.sv]
`default_nettype none

interface prs_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] error_code;
  logic [2:0] error_device;
  logic       busy_res;
  logic [7:0] device_on;
  logic [7:0] pin_levels;
  logic       applied_valid;
  logic [2:0] applied_device;

  modport source (output valid, output accepted, output error_code, output error_device,
                  output busy_res, output device_on, output pin_levels,
                  output applied_valid, output applied_device, input ready);
  modport sink   (input valid, input accepted, input error_code, input error_device,
                  input busy_res, input device_on, input pin_levels,
                  input applied_valid, input applied_device, output ready);
endinterface

`default_nettype wire

[rtl/core/prs_cfg_if.sv]
`default_nettype none

interface prs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [63:0] data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/prs_front.sv]
`default_nettype none

// Accepts input transactions and turns the op code into a command kind.
module prs_front (
  prs_in_if.sink          in_ch,
  input  wire logic       fifo_full,
  output logic            push,
  output prs_pkg::cmd_t   cmd
);

  prs_pkg::cmd_kind_t kind;

  always_comb begin
    unique case (in_ch.op)
      prs_pkg::OP_TICK:    kind = prs_pkg::K_TICK;
      prs_pkg::OP_LIST:    kind = prs_pkg::K_LIST;
      prs_pkg::OP_GROUP:   kind = prs_pkg::K_GROUP;
      prs_pkg::OP_ALL_OFF: kind = prs_pkg::K_ALL_OFF;
      prs_pkg::OP_INIT:    kind = prs_pkg::K_INIT;
      default:             kind = prs_pkg::K_NOP;
    endcase
  end

  assign in_ch.ready       = !fifo_full;
  assign push              = in_ch.valid && !fifo_full;
  assign cmd.kind          = kind;
  assign cmd.device        = in_ch.device;
  assign cmd.turn_on       = in_ch.turn_on;
  assign cmd.group_number  = in_ch.group_number;
  assign cmd.last_item     = in_ch.last_item;

endmodule

`default_nettype wire

[rtl/core/prs_cmd_fifo.sv]
`default_nettype none

// Short command queue between the front and the back.
module prs_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  prs_pkg::cmd_t      cmd_in,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output prs_pkg::cmd_t      cmd_out
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  prs_pkg::cmd_t  mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign cmd_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

[rtl/core/prs_back.sv]
`default_nettype none

// Executes commands: builds the action queue, walks groups one device per
// cycle, steps the switching sequence on ticks and registers one result.
module prs_back #(
  parameter int MAX_DEVICES = 8,
  parameter int QUEUE_DEPTH = 8,
  parameter int DELAY_BITS  = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  prs_pkg::cfg_regs_t  cfg,
  input  wire logic           fifo_valid,
  input  prs_pkg::cmd_t       cmd,
  output logic                fifo_pop,
  input  wire logic           out_ready,
  output logic                out_valid,
  output prs_pkg::result_t    out_data
);

  localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  prs_pkg::back_state_t state_r, state_nxt;

  logic [2:0]            q_dev_r [QUEUE_DEPTH];
  logic                  q_st_r  [QUEUE_DEPTH];
  logic                  q_we;
  logic [QIW-1:0]        q_widx;
  logic [2:0]            q_wdev;
  logic                  q_wst;

  logic [7:0]            on_r, on_nxt;
  logic [CW-1:0]         total_r, total_nxt;
  logic [CW-1:0]         next_r, next_nxt;
  logic                  busy_r, busy_nxt;
  logic                  waiting_r, waiting_nxt;
  logic [DELAY_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [DELAY_BITS-1:0] target_r, target_nxt;
  logic                  collecting_r, collecting_nxt;
  logic                  aborted_r, aborted_nxt;
  logic [2:0]            err_r, err_nxt;
  logic [2:0]            err_dev_r, err_dev_nxt;

  logic [3:0]            walk_i_r, walk_i_nxt;
  logic                  walk_on_r, walk_on_nxt;
  logic [2:0]            walk_grp_r, walk_grp_nxt;
  logic                  walk_is_grp_r, walk_is_grp_nxt;
  logic                  walk_ok_r, walk_ok_nxt;

  logic                  out_valid_r, out_valid_nxt;
  prs_pkg::result_t      out_data_r, out_data_nxt;

  logic                  slot_free;
  logic [3:0]            live;
  logic                  walk_end;
  logic                  walk_match;
  logic                  queue_full;
  logic                  list_clear;
  logic [CW-1:0]         total_eff;
  logic                  hit_same;
  logic                  hit_conf;
  logic [2:0]            head_dev;
  logic                  head_st;
  logic [127:0]          delays;
  logic [15:0]           head_delay;
  logic [DELAY_BITS-1:0] elapsed_inc;
  logic                  tick_go;
  logic                  res_emit;
  logic                  res_ok;
  logic                  res_applied;
  logic [2:0]            res_adev;

  assign slot_free  = !out_valid_r || out_ready;
  assign live       = (cfg.device_count > 4'(MAX_DEVICES)) ? 4'(MAX_DEVICES)
                                                           : cfg.device_count;
  assign walk_end   = (walk_i_r >= live);
  assign walk_match = !walk_is_grp_r ||
                      (cfg.group_map[{2'b00, walk_i_r[2:0]} * 5'd3 +: 3] == walk_grp_r);
  assign queue_full = (total_r >= CW'(QUEUE_DEPTH));

  // First item of a list on an idle sequencer starts from an empty queue.
  assign list_clear = !collecting_r && !busy_r;
  assign total_eff  = list_clear ? '0 : total_r;

  always_comb begin
    hit_same = 1'b0;
    hit_conf = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if ((CW'(i) < total_eff) && (q_dev_r[i] == cmd.device)) begin
        if (q_st_r[i] == cmd.turn_on) begin
          hit_same = 1'b1;
        end else begin
          hit_conf = 1'b1;
        end
      end
    end
  end

  assign head_dev    = q_dev_r[next_r[QIW-1:0]];
  assign head_st     = q_st_r[next_r[QIW-1:0]];
  assign delays      = {cfg.delay_table_high, cfg.delay_table_low};
  assign head_delay  = delays[{head_dev, 4'b0000} +: 16];
  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign tick_go     = !waiting_r || (elapsed_inc >= target_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prs_pkg::BK_IDLE: begin
        if (fifo_valid && slot_free && !busy_r &&
            (cmd.kind == prs_pkg::K_GROUP || cmd.kind == prs_pkg::K_ALL_OFF)) begin
          state_nxt = prs_pkg::BK_WALK;
        end
      end
      prs_pkg::BK_WALK: begin
        if (walk_end || (walk_match && queue_full)) begin
          state_nxt = prs_pkg::BK_FINISH;
        end
      end
      prs_pkg::BK_FINISH: begin
        if (slot_free) begin
          state_nxt = prs_pkg::BK_IDLE;
        end
      end
      default: state_nxt = prs_pkg::BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    on_nxt          = on_r;
    total_nxt       = total_r;
    next_nxt        = next_r;
    busy_nxt        = busy_r;
    waiting_nxt     = waiting_r;
    elapsed_nxt     = elapsed_r;
    target_nxt      = target_r;
    collecting_nxt  = collecting_r;
    aborted_nxt     = aborted_r;
    err_nxt         = err_r;
    err_dev_nxt     = err_dev_r;
    walk_i_nxt      = walk_i_r;
    walk_on_nxt     = walk_on_r;
    walk_grp_nxt    = walk_grp_r;
    walk_is_grp_nxt = walk_is_grp_r;
    walk_ok_nxt     = walk_ok_r;
    q_we            = 1'b0;
    q_widx          = total_r[QIW-1:0];
    q_wdev          = cmd.device;
    q_wst           = cmd.turn_on;
    fifo_pop        = 1'b0;
    res_emit        = 1'b0;
    res_ok          = 1'b0;
    res_applied     = 1'b0;
    res_adev        = 3'd0;

    unique case (state_r)
      prs_pkg::BK_IDLE: begin
        if (fifo_valid && slot_free) begin
          fifo_pop = 1'b1;
          unique case (cmd.kind)
            prs_pkg::K_TICK: begin
              res_emit = 1'b1;
              if (busy_r) begin
                if (waiting_r) begin
                  elapsed_nxt = elapsed_inc;
                  if (tick_go) begin
                    waiting_nxt = 1'b0;
                  end
                end
                if (tick_go) begin
                  if (next_r >= total_r) begin
                    busy_nxt = 1'b0;
                  end else begin
                    on_nxt[head_dev] = head_st;
                    res_applied      = 1'b1;
                    res_adev         = head_dev;
                    next_nxt         = next_r + 1'b1;
                    if (next_r + 1'b1 >= total_r) begin
                      busy_nxt = 1'b0;
                    end else begin
                      target_nxt  = head_delay[DELAY_BITS-1:0];
                      elapsed_nxt = '0;
                      waiting_nxt = (head_delay[DELAY_BITS-1:0] != '0);
                    end
                  end
                end
              end
            end
            prs_pkg::K_LIST: begin
              res_emit = 1'b1;
              if (!collecting_r) begin
                collecting_nxt = 1'b1;
                if (busy_r) begin
                  err_nxt     = prs_pkg::ERR_BUSY;
                  err_dev_nxt = 3'd0;
                  aborted_nxt = 1'b1;
                end else begin
                  total_nxt   = '0;
                  next_nxt    = '0;
                  waiting_nxt = 1'b0;
                  err_nxt     = prs_pkg::ERR_NONE;
                  err_dev_nxt = 3'd0;
                  aborted_nxt = 1'b0;
                end
              end
              if (!aborted_nxt) begin
                if ({1'b0, cmd.device} >= live) begin
                  err_nxt     = prs_pkg::ERR_UNKNOWN_DEVICE;
                  err_dev_nxt = cmd.device;
                  aborted_nxt = 1'b1;
                end else if (hit_conf) begin
                  err_nxt     = prs_pkg::ERR_CONFLICT;
                  err_dev_nxt = cmd.device;
                  aborted_nxt = 1'b1;
                end else if (hit_same) begin
                  res_ok = 1'b1;
                end else if (total_eff >= CW'(QUEUE_DEPTH)) begin
                  err_nxt     = prs_pkg::ERR_TOO_MANY;
                  err_dev_nxt = 3'd0;
                  aborted_nxt = 1'b1;
                end else begin
                  q_we      = 1'b1;
                  q_widx    = total_eff[QIW-1:0];
                  total_nxt = total_eff + 1'b1;
                  res_ok    = 1'b1;
                end
              end
              if (cmd.last_item) begin
                if (!aborted_nxt) begin
                  next_nxt    = '0;
                  waiting_nxt = 1'b0;
                  busy_nxt    = 1'b1;
                  err_nxt     = prs_pkg::ERR_NONE;
                  err_dev_nxt = 3'd0;
                end
                collecting_nxt = 1'b0;
                aborted_nxt    = 1'b0;
              end
            end
            prs_pkg::K_GROUP, prs_pkg::K_ALL_OFF: begin
              collecting_nxt = 1'b0;
              aborted_nxt    = 1'b0;
              if (busy_r) begin
                err_nxt     = prs_pkg::ERR_BUSY;
                err_dev_nxt = 3'd0;
                res_emit    = 1'b1;
              end else begin
                total_nxt       = '0;
                next_nxt        = '0;
                waiting_nxt     = 1'b0;
                err_nxt         = prs_pkg::ERR_NONE;
                err_dev_nxt     = 3'd0;
                walk_i_nxt      = 4'd0;
                walk_is_grp_nxt = (cmd.kind == prs_pkg::K_GROUP);
                walk_on_nxt     = (cmd.kind == prs_pkg::K_GROUP) ? cmd.turn_on : 1'b0;
                walk_grp_nxt    = cmd.group_number;
              end
            end
            prs_pkg::K_INIT: begin
              res_emit       = 1'b1;
              collecting_nxt = 1'b0;
              aborted_nxt    = 1'b0;
              for (int i = 0; i < 8; i++) begin
                if (4'(i) < live) begin
                  on_nxt[i] = cfg.default_on_mask[i];
                end
              end
            end
            default: begin
              res_emit = 1'b1;
            end
          endcase
        end
      end
      prs_pkg::BK_WALK: begin
        if (walk_end) begin
          if (walk_is_grp_r && (total_r == '0)) begin
            err_nxt     = prs_pkg::ERR_UNKNOWN_GROUP;
            err_dev_nxt = walk_grp_r;
            walk_ok_nxt = 1'b0;
          end else begin
            next_nxt    = '0;
            waiting_nxt = 1'b0;
            busy_nxt    = 1'b1;
            err_nxt     = prs_pkg::ERR_NONE;
            err_dev_nxt = 3'd0;
            walk_ok_nxt = 1'b1;
          end
        end else if (walk_match && queue_full) begin
          err_nxt     = prs_pkg::ERR_TOO_MANY;
          err_dev_nxt = 3'd0;
          walk_ok_nxt = 1'b0;
        end else begin
          if (walk_match) begin
            q_we      = 1'b1;
            q_widx    = total_r[QIW-1:0];
            q_wdev    = walk_i_r[2:0];
            q_wst     = walk_on_r;
            total_nxt = total_r + 1'b1;
          end
          walk_i_nxt = walk_i_r + 4'd1;
        end
      end
      prs_pkg::BK_FINISH: begin
        if (slot_free) begin
          res_emit = 1'b1;
          res_ok   = walk_ok_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_emit) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.accepted       = res_ok;
      out_data_nxt.error_code     = err_nxt;
      out_data_nxt.error_device   = err_dev_nxt;
      out_data_nxt.busy_res       = busy_nxt;
      out_data_nxt.device_on      = on_nxt;
      out_data_nxt.pin_levels     = ~(on_nxt ^ cfg.active_high_mask);
      out_data_nxt.applied_valid  = res_applied;
      out_data_nxt.applied_device = res_adev;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= prs_pkg::BK_IDLE;
      on_r         <= '0;
      total_r      <= '0;
      next_r       <= '0;
      busy_r       <= 1'b0;
      waiting_r    <= 1'b0;
      elapsed_r    <= '0;
      target_r     <= '0;
      collecting_r <= 1'b0;
      aborted_r    <= 1'b0;
      err_r        <= prs_pkg::ERR_NONE;
      err_dev_r    <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      on_r         <= on_nxt;
      total_r      <= total_nxt;
      next_r       <= next_nxt;
      busy_r       <= busy_nxt;
      waiting_r    <= waiting_nxt;
      elapsed_r    <= elapsed_nxt;
      target_r     <= target_nxt;
      collecting_r <= collecting_nxt;
      aborted_r    <= aborted_nxt;
      err_r        <= err_nxt;
      err_dev_r    <= err_dev_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_i_r      <= walk_i_nxt;
    walk_on_r     <= walk_on_nxt;
    walk_grp_r    <= walk_grp_nxt;
    walk_is_grp_r <= walk_is_grp_nxt;
    walk_ok_r     <= walk_ok_nxt;
    out_data_r    <= out_data_nxt;
    if (q_we) begin
      q_dev_r[q_widx] <= q_wdev;
      q_st_r[q_widx]  <= q_wst;
    end
  end

endmodule

`default_nettype wire

[rtl/core/power_rail_sequencer.sv]
// Channel  Port    Direction  Payload
// -------  ------  ---------  -----------------------------------------------------------
// input    in_ch   sink       op, device, turn_on, group_number, last_item
// result   out_ch  source     accepted, error_code, error_device, busy_res, device_on,
//                             pin_levels, applied_valid, applied_device
// config   cfg_ch  sink       reg_index, data (always ready)
//
// Every input transaction yields exactly one result transaction, in order.
// Ticks, list items, init, unused op codes and group or all-off commands refused as
// busy are popped and have their result registered in the same cycle in the back end.
// Other group and all-off commands are popped, then walk the live devices one device per
// cycle to fill the action queue, then register the result once the result slot is free.
// A queue-full stop ends the walk early. At the earliest, out_ch.valid rises once an
// accepted transaction has passed through the command queue and the result register.
// Reset (rst_n low, synchronous) clears all control state and loads the register reset
// values. The two-entry command queue keeps in_ch.ready high while out_ch is stalled
// until that queue fills.
`default_nettype none

module power_rail_sequencer #(
  parameter int MAX_DEVICES = 8,
  parameter int QUEUE_DEPTH = 8,
  parameter int DELAY_BITS  = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  prs_in_if.sink     in_ch,
  prs_out_if.source  out_ch,
  prs_cfg_if.sink    cfg_ch
);

  // Configuration registers. Writes are only expected while the block is idle,
  // so the back end reads them directly.
  prs_pkg::cfg_regs_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        prs_pkg::CFG_DEVICE_COUNT:     cfg_nxt.device_count     = cfg_ch.data[3:0];
        prs_pkg::CFG_ACTIVE_HIGH_MASK: cfg_nxt.active_high_mask = cfg_ch.data[7:0];
        prs_pkg::CFG_DEFAULT_ON_MASK:  cfg_nxt.default_on_mask  = cfg_ch.data[7:0];
        prs_pkg::CFG_GROUP_MAP:        cfg_nxt.group_map        = cfg_ch.data[23:0];
        prs_pkg::CFG_DELAY_LOW:        cfg_nxt.delay_table_low  = cfg_ch.data;
        prs_pkg::CFG_DELAY_HIGH:       cfg_nxt.delay_table_high = cfg_ch.data;
        default: begin
          // Indexes past the register list are accepted and dropped.
        end
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_count     <= 4'd0;
      cfg_r.active_high_mask <= 8'hFF;
      cfg_r.default_on_mask  <= 8'h00;
      cfg_r.group_map        <= 24'd0;
      cfg_r.delay_table_low  <= 64'd0;
      cfg_r.delay_table_high <= 64'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: accepts transactions and classifies the op code.
  logic          push;
  logic          fifo_full;
  prs_pkg::cmd_t front_cmd;

  prs_front u_front (
    .in_ch     (in_ch),
    .fifo_full (fifo_full),
    .push      (push),
    .cmd       (front_cmd)
  );

  // Command queue that decouples acceptance from execution.
  logic          fifo_valid;
  logic          fifo_pop;
  prs_pkg::cmd_t back_cmd;

  prs_cmd_fifo #(
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (front_cmd),
    .full    (fifo_full),
    .pop     (fifo_pop),
    .valid   (fifo_valid),
    .cmd_out (back_cmd)
  );

  // Back end: executes commands and holds the result register.
  logic             res_valid;
  prs_pkg::result_t res_data;

  prs_back #(
    .MAX_DEVICES (MAX_DEVICES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DELAY_BITS  (DELAY_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_valid (fifo_valid),
    .cmd        (back_cmd),
    .fifo_pop   (fifo_pop),
    .out_ready  (out_ch.ready),
    .out_valid  (res_valid),
    .out_data   (res_data)
  );

  assign out_ch.valid          = res_valid;
  assign out_ch.accepted       = res_data.accepted;
  assign out_ch.error_code     = res_data.error_code;
  assign out_ch.error_device   = res_data.error_device;
  assign out_ch.busy_res       = res_data.busy_res;
  assign out_ch.device_on      = res_data.device_on;
  assign out_ch.pin_levels     = res_data.pin_levels;
  assign out_ch.applied_valid  = res_data.applied_valid;
  assign out_ch.applied_device = res_data.applied_device;

endmodule

`default_nettype wire

[rtl/core/prs_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module prs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       accepted,
  input wire logic [2:0] error_code,
  input wire logic [2:0] error_device,
  input wire logic       applied_valid,
  input wire logic [2:0] applied_device
);

  logic err_no_dev;

  assign err_no_dev = (error_code == prs_pkg::ERR_NONE) ||
                      (error_code == prs_pkg::ERR_BUSY) ||
                      (error_code == prs_pkg::ERR_TOO_MANY);

  // A stalled result stays offered.
  `PRS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // An accepted command never reports an error.
  `PRS_ASSERT_IMP(a_ok_no_err, clk, rst_n, out_valid && accepted, error_code == prs_pkg::ERR_NONE)

  // Only ticks apply actions and ticks are never accepted as commands.
  `PRS_ASSERT_IMP(a_tick_excl, clk, rst_n, out_valid && applied_valid, !accepted)

  // The applied device reads zero when nothing was switched.
  `PRS_ASSERT_IMP(a_adev_zero, clk, rst_n, out_valid && !applied_valid, applied_device == 3'd0)

  // Busy, queue-full and no-error results carry no device.
  `PRS_ASSERT_IMP(a_edev_zero, clk, rst_n, out_valid && err_no_dev, error_device == 3'd0)

endmodule

bind power_rail_sequencer prs_checker u_prs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .accepted       (out_ch.accepted),
  .error_code     (out_ch.error_code),
  .error_device   (out_ch.error_device),
  .applied_valid  (out_ch.applied_valid),
  .applied_device (out_ch.applied_device)
);

`default_nettype wire
